FILE: hdl/bounded_deque_assert.svh
// Assertion macros shared by the deque RTL.
`ifndef BOUNDED_DEQUE_ASSERT_SVH
`define BOUNDED_DEQUE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge out of reset.
`define BD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define BD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define BD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: hdl/bd_pkg.sv
// Shared types and codes for the bounded deque.
package bd_pkg;

    localparam int DATA_W   = 32;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 3;

    // Command codes carried on the input channel.
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd4;

    // Status codes carried on the output channel.
    localparam logic [STATUS_W-1:0] ST_ELEMENT   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_HALTED    = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_REPORT,
        S_PRIME,
        S_DUMP
    } bd_state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic                push_front;
        logic                push_rear;
        logic                pop_front;
        logic                pop_rear;
        logic                set_halt;
        logic                pend_load;
        logic [STATUS_W-1:0] pend_code;
        logic                report_load;
        logic                dump_start;
        logic                prime;
        logic                dump_step;
    } bd_ctl_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic empty;
        logic full;
        logic halted;
        logic out_free;
        logic dump_last;
    } bd_sts_t;

endpackage

FILE: hdl/bounded_deque.sv
// Top level of the bounded deque: ring-buffer double-ended queue of 32-bit values.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+---------------------------
//   input    | in        | in_valid / in_stall  | cmd[2:0], value[31:0]
//   output   | out       | out_valid / out_stall| data[31:0], status[2:0], last
//
// Push and pop act as they are accepted and give no item out; an item that
// reports (underflow, overflow, empty, halted) waits in the report state, which
// holds the input until the output is free and then loads the output register.
// A dump holds the input through its accept, the prime state for the first
// memory read, then the dump state, which loads one stored element whenever
// the output is free, read ahead through the single registered read port of slots.
// Reset clears indices, fill count, the halted flag and the state machine;
// slot contents stay undefined until pushed. A stall on the output holds the
// report or the dump walker; the input stays stalled until the final item of
// the run is loaded into the output register.
`include "bounded_deque_assert.svh"

module bounded_deque #(
    parameter int DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         cmd,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] data,
    output logic [2:0]         status,
    output logic               last
);
    import bd_pkg::*;

    bd_ctl_t ctl;
    bd_sts_t sts;
    logic    ring_push;
    logic    ring_change;
    logic    out_load;

    // Sequence each item: decode, report, or walk the ring for a dump.
    bd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .cmd      (cmd),
        .sts      (sts),
        .ctl      (ctl),
        .in_stall (in_stall)
    );

    // Hold slots, indices and the output register.
    bd_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .value     (value),
        .out_stall (out_stall),
        .sts       (sts),
        .out_valid (out_valid),
        .data      (data),
        .status    (status),
        .last      (last)
    );

    // Summaries of the commands for the checks below.
    assign ring_push   = ctl.push_front || ctl.push_rear;
    assign ring_change = ring_push || ctl.pop_front || ctl.pop_rear;
    assign out_load    = ctl.dump_step || ctl.report_load;

    // Once halted, never touch the queue again.
    `BD_ASSERT_IMP(a_halt_freeze, clk, rst_n, sts.halted, !ring_change, "queue moved while halted")
    // Never push into a full ring.
    `BD_ASSERT_IMP(a_no_push_full, clk, rst_n, ring_push, !sts.full, "push while full")
    // Never overwrite an output item that is still waiting.
    `BD_ASSERT_IMP(a_out_free, clk, rst_n, out_load, sts.out_free, "output overwritten")
    // An underflow halts the block from the next cycle on.
    `BD_ASSERT_NXT(a_halt_set, clk, rst_n, ctl.set_halt, sts.halted, "halt flag not set")

endmodule

FILE: hdl/bd_ctrl.sv
// Control state machine of the bounded deque.
module bd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [2:0]       cmd,
    input  bd_pkg::bd_sts_t  sts,
    output bd_pkg::bd_ctl_t  ctl,
    output logic             in_stall
);
    import bd_pkg::*;

    bd_state_t           state_reg;
    bd_state_t           state_next;
    logic                fire;
    logic                want_report;
    logic [STATUS_W-1:0] report_code;
    logic                want_dump;

    assign fire     = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);

    // Classify the item at the input.
    always_comb
    begin
        want_report = 1'b0;
        report_code = ST_HALTED;
        want_dump   = 1'b0;
        if (sts.halted)
        begin
            want_report = 1'b1;
            report_code = ST_HALTED;
        end
        else
        begin
            unique case (cmd) inside
                CMD_PUSH_FRONT, CMD_PUSH_REAR:
                begin
                    want_report = sts.full;
                    report_code = ST_OVERFLOW;
                end
                CMD_POP_FRONT, CMD_POP_REAR:
                begin
                    want_report = sts.empty;
                    report_code = ST_UNDERFLOW;
                end
                CMD_DUMP:
                begin
                    want_report = sts.empty;
                    report_code = ST_EMPTY;
                    want_dump   = !sts.empty;
                end
                default:
                begin
                    want_report = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (fire && want_report)
                    state_next = S_REPORT;
                else if (fire && want_dump)
                    state_next = S_PRIME;
            end
            S_REPORT:
            begin
                if (sts.out_free)
                    state_next = S_IDLE;
            end
            S_PRIME:
            begin
                state_next = S_DUMP;
            end
            S_DUMP:
            begin
                if (sts.out_free && sts.dump_last)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl = '0;
        ctl.pend_code = report_code;
        unique case (state_reg)
            S_IDLE:
            begin
                if (fire && !sts.halted)
                begin
                    ctl.push_front = (cmd == CMD_PUSH_FRONT) && !sts.full;
                    ctl.push_rear  = (cmd == CMD_PUSH_REAR) && !sts.full;
                    ctl.pop_front  = (cmd == CMD_POP_FRONT) && !sts.empty;
                    ctl.pop_rear   = (cmd == CMD_POP_REAR) && !sts.empty;
                    ctl.set_halt   = ((cmd == CMD_POP_FRONT) || (cmd == CMD_POP_REAR))
                                     && sts.empty;
                end
                ctl.pend_load  = fire && want_report;
                ctl.dump_start = fire && want_dump;
            end
            S_REPORT:
            begin
                ctl.report_load = sts.out_free;
            end
            S_PRIME:
            begin
                ctl.prime = 1'b1;
            end
            S_DUMP:
            begin
                ctl.dump_step = sts.out_free;
            end
            default:
            begin
                ctl.prime = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

FILE: hdl/bd_datapath.sv
// Ring buffer storage, indices, dump walker and output register.
module bd_datapath #(
    parameter int DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  bd_pkg::bd_ctl_t    ctl,
    input  logic signed [31:0] value,
    input  logic               out_stall,
    output bd_pkg::bd_sts_t    sts,
    output logic               out_valid,
    output logic signed [31:0] data,
    output logic [2:0]         status,
    output logic               last
);
    import bd_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

    logic [DATA_W-1:0]   mem [DEPTH];

    logic [IDX_W-1:0]    front_reg;
    logic [IDX_W-1:0]    front_next;
    logic [IDX_W-1:0]    rear_reg;
    logic [IDX_W-1:0]    rear_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                halted_reg;
    logic [IDX_W-1:0]    ptr_reg;
    logic [IDX_W-1:0]    ptr_next;
    logic [CNT_W-1:0]    remain_reg;
    logic [CNT_W-1:0]    remain_next;
    logic [STATUS_W-1:0] pend_reg;
    logic [DATA_W-1:0]   rd_data_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [DATA_W-1:0]   data_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                last_reg;

    logic [IDX_W-1:0]    front_prev;
    logic [IDX_W-1:0]    front_inc;
    logic [IDX_W-1:0]    rear_prev;
    logic [IDX_W-1:0]    rear_inc;
    logic [IDX_W-1:0]    ptr_inc;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic                rd_en;

    assign front_prev = (front_reg == '0) ? LAST_IDX : front_reg - IDX_W'(1);
    assign front_inc  = (front_reg == LAST_IDX) ? '0 : front_reg + IDX_W'(1);
    assign rear_prev  = (rear_reg == '0) ? LAST_IDX : rear_reg - IDX_W'(1);
    assign rear_inc   = (rear_reg == LAST_IDX) ? '0 : rear_reg + IDX_W'(1);
    assign ptr_inc    = (ptr_reg == LAST_IDX) ? '0 : ptr_reg + IDX_W'(1);

    assign sts.empty     = (count_reg == '0);
    assign sts.full      = (count_reg >= FULL_CNT);
    assign sts.halted    = halted_reg;
    assign sts.out_free  = !out_valid_reg || !out_stall;
    assign sts.dump_last = (remain_reg == ONE_CNT);

    assign wr_en   = ctl.push_front || ctl.push_rear;
    assign wr_addr = ctl.push_front ? front_prev : rear_reg;
    // Read ahead one slot so a dump streams one element per cycle while the output is not stalled.
    assign rd_en   = ctl.prime || (ctl.dump_step && !sts.dump_last);

    always_comb
    begin
        front_next = front_reg;
        rear_next  = rear_reg;
        count_next = count_reg;
        if (ctl.push_front)
            front_next = front_prev;
        if (ctl.pop_front)
            front_next = front_inc;
        if (ctl.push_rear)
            rear_next = rear_inc;
        if (ctl.pop_rear)
            rear_next = rear_prev;
        if (wr_en)
            count_next = count_reg + ONE_CNT;
        else if (ctl.pop_front || ctl.pop_rear)
            count_next = count_reg - ONE_CNT;
    end

    always_comb
    begin
        ptr_next    = ptr_reg;
        remain_next = remain_reg;
        if (ctl.dump_start)
        begin
            ptr_next    = front_reg;
            remain_next = count_reg;
        end
        else
        begin
            if (rd_en)
                ptr_next = ptr_inc;
            if (ctl.dump_step)
                remain_next = remain_reg - ONE_CNT;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.report_load || ctl.dump_step)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= value;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            rear_reg      <= '0;
            count_reg     <= '0;
            halted_reg    <= 1'b0;
            ptr_reg       <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            front_reg     <= front_next;
            rear_reg      <= rear_next;
            count_reg     <= count_next;
            halted_reg    <= halted_reg || ctl.set_halt;
            ptr_reg       <= ptr_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.pend_load)
            pend_reg <= ctl.pend_code;
        if (ctl.report_load)
        begin
            data_reg   <= '0;
            status_reg <= pend_reg;
            last_reg   <= 1'b1;
        end
        else if (ctl.dump_step)
        begin
            data_reg   <= rd_data_reg;
            status_reg <= ST_ELEMENT;
            last_reg   <= sts.dump_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign data      = signed'(data_reg);
    assign status    = status_reg;
    assign last      = last_reg;

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the bounded deque: directed, backpressure and random tests.
`timescale 1ns / 1ps

module testbench;
    import bd_pkg::*;

    // Capacity of the block as built with its default parameter.
    localparam int SLOTS = 64;
    // Idle cycles to allow after the last expected item before the block is considered quiet.
    localparam int SETTLE_CYCLES = 16;
    // Cycles the receiver holds off in the long backpressure stretch.
    localparam int LONG_HOLD_CYCLES = 300;
    // Hard ceiling on the run, far above the slowest legal run.
    localparam int CYCLE_LIMIT = 400000;
    // Random items to send, not counting commands the block ignores.
    localparam int RANDOM_ITEMS = 24;

    // Codes above CMD_DUMP are not commands; the block ignores them unless halted.
    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

    typedef struct {
        logic signed [DATA_W-1:0] data;
        logic [STATUS_W-1:0]      status;
        logic                     last;
    } deque_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [CMD_W-1:0]         cmd = CMD_PUSH_FRONT;
    logic signed [DATA_W-1:0] value = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [DATA_W-1:0] data;
    logic [STATUS_W-1:0]      status;
    logic                     last;

    bounded_deque DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .data      (data),
        .status    (status),
        .last      (last)
    );

    // Shadow copy of the deque, advanced once per accepted item.
    logic signed [DATA_W-1:0] shadow_slots [SLOTS];
    logic [5:0]               head_idx = '0;
    logic [5:0]               tail_idx = '0;
    logic [6:0]               occupancy = '0;
    logic                     is_halted = 1'b0;

    // Items the block still owes, oldest first.
    deque_result_t            pending_results [$];

    int                       errors = 0;
    int                       cycle_count = 0;
    int                       burst_left = 0;
    int                       gap_max = 4;
    logic                     hold_req = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Bound the run: a hung handshake must not spin forever.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("FAIL bounded_deque");
            $finish;
        end
    end

    // Queue one expected item.
    function automatic void owe_result(logic signed [DATA_W-1:0] d,
                                       logic [STATUS_W-1:0] s, logic l);
        deque_result_t r;
        r.data = d;
        r.status = s;
        r.last = l;
        pending_results.push_back(r);
    endfunction

    // Advance the shadow deque by one accepted item and queue what it owes.
    // A halted block answers everything with a single halted item; pops on
    // empty set the halt, pushes on full are dropped with an overflow item,
    // and a dump walks front to rear marking the final element.
    function automatic void deque_apply(logic [CMD_W-1:0] c, logic signed [DATA_W-1:0] v);
        logic [5:0] walk;
        int         k;
        if (is_halted)
        begin
            owe_result('0, ST_HALTED, 1'b1);
            return;
        end
        case (c)
            CMD_PUSH_FRONT, CMD_PUSH_REAR:
            begin
                if (occupancy == SLOTS)
                    owe_result('0, ST_OVERFLOW, 1'b1);
                else
                begin
                    if (c == CMD_PUSH_FRONT)
                    begin
                        head_idx = head_idx - 6'd1;
                        shadow_slots[head_idx] = v;
                    end
                    else
                    begin
                        shadow_slots[tail_idx] = v;
                        tail_idx = tail_idx + 6'd1;
                    end
                    occupancy = occupancy + 7'd1;
                end
            end
            CMD_POP_FRONT, CMD_POP_REAR:
            begin
                if (occupancy == 0)
                begin
                    is_halted = 1'b1;
                    owe_result('0, ST_UNDERFLOW, 1'b1);
                end
                else
                begin
                    if (c == CMD_POP_FRONT)
                        head_idx = head_idx + 6'd1;
                    else
                        tail_idx = tail_idx - 6'd1;
                    occupancy = occupancy - 7'd1;
                end
            end
            CMD_DUMP:
            begin
                if (occupancy == 0)
                    owe_result('0, ST_EMPTY, 1'b1);
                else
                begin
                    walk = head_idx;
                    for (k = 0; k < occupancy; k++)
                    begin
                        owe_result(shadow_slots[walk], ST_ELEMENT, (k + 1 == occupancy));
                        walk = walk + 6'd1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    // Offer one item, holding it until accepted. The sender runs in bursts:
    // when a burst is spent, drop valid for a random gap and pick a new length.
    task automatic send_item(logic [CMD_W-1:0] c, logic signed [DATA_W-1:0] v);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, gap_max);
            burst_left = $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        cmd <= c;
        value <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        deque_apply(c, v);
        burst_left--;
    endtask

    // Drop valid and wait until every owed item has come, then let the block settle.
    task automatic wait_drain();
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly random words, with the corner values mixed in.
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return '0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Receiver: stall on a pattern that changes mode at random intervals
    // (no stall, light random, periodic, heavy random). On request, hold off
    // for a long counted stretch so the block backs up into its input.
    initial
    begin
        int mode;
        int mode_left;
        int phase;
        int hold_left;
        mode = 0;
        mode_left = 0;
        phase = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            phase++;
            if (hold_req)
            begin
                hold_left = LONG_HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 99) < 30);
                    2: out_stall <= (phase % 3 == 0);
                    default: out_stall <= ($urandom_range(0, 99) < 75);
                endcase
            end
        end
    end

    // Compare every accepted output item against the oldest owed item.
    always @(posedge clk)
    begin
        deque_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected item data=%0d status=%0d last=%0b",
                         $time, data, status, last);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (data !== want.data)
                begin
                    $display("%0t: data expected %0d actual %0d", $time, want.data, data);
                    errors++;
                end
                if (status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, status);
                    errors++;
                end
                if (last !== want.last)
                begin
                    $display("%0t: last expected %0b actual %0b", $time, want.last, last);
                    errors++;
                end
            end
        end
    end

    // Every command once, extremes of value, dump of an empty queue, front
    // index wrap on the first front push, and the ignored codes.
    task automatic test_basic_ops();
        send_item(CMD_DUMP, $urandom);
        send_item(CMD_PUSH_REAR, 32'sh8000_0000);
        send_item(CMD_PUSH_FRONT, 32'sh7fff_ffff);
        send_item(CMD_PUSH_REAR, '0);
        send_item(CMD_PUSH_FRONT, -32'sd1);
        send_item(CMD_PUSH_REAR, 32'sh5555_aaaa);
        send_item(CMD_DUMP, $urandom);
        send_item(CMD_POP_FRONT, $urandom);
        send_item(CMD_POP_REAR, $urandom);
        send_item(CMD_DUMP, '0);
        send_item(CMD_UNUSED_LO, $urandom);
        send_item(3'd6, $urandom);
        send_item(CMD_UNUSED_HI, $urandom);
        send_item(CMD_DUMP, -32'sd1);
        send_item(CMD_POP_REAR, $urandom);
        send_item(CMD_POP_FRONT, $urandom);
        send_item(CMD_POP_FRONT, $urandom);
        send_item(CMD_DUMP, $urandom);
        wait_drain();
    endtask

    // Fill to capacity, push both ends while full, dump the ring, pop to three, dump again.
    task automatic test_fill_overflow();
        int n;
        for (n = 0; n < SLOTS; n++)
            send_item($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_REAR, pick_value());
        send_item(CMD_PUSH_FRONT, $urandom);
        send_item(CMD_PUSH_REAR, $urandom);
        send_item(CMD_DUMP, $urandom);
        for (n = 0; n < SLOTS - 3; n++)
            send_item($urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_REAR, $urandom);
        send_item(CMD_DUMP, $urandom);
        wait_drain();
    endtask

    // Hold the receiver off while the sender keeps offering: the dump stalls
    // in the output, the input backs up behind it. Then pause until drained.
    task automatic test_backpressure();
        int n;
        gap_max = 0;
        for (n = 0; n < 8; n++)
            send_item(CMD_PUSH_REAR, pick_value());
        hold_req = 1'b1;
        send_item(CMD_DUMP, $urandom);
        for (n = 0; n < 6; n++)
            send_item(CMD_PUSH_FRONT, pick_value());
        send_item(CMD_DUMP, $urandom);
        send_item(CMD_POP_REAR, $urandom);
        send_item(CMD_DUMP, $urandom);
        wait_drain();
        gap_max = 4;
    endtask

    // Random traffic in segments that grow, shrink or churn the deque. Pops
    // never hit an empty deque here, so the block stays live for later tests.
    task automatic test_random();
        int sent;
        int seg_left;
        int bias;
        int roll;
        logic [CMD_W-1:0] c;
        sent = 0;
        seg_left = 0;
        bias = 50;
        while (sent < RANDOM_ITEMS)
        begin
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(10, 40);
                bias = $urandom_range(0, 2) * 35 + 15;
                gap_max = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
                if ($urandom_range(0, 3) == 0)
                    wait_drain();
            end
            seg_left--;
            roll = $urandom_range(0, 99);
            if (roll < 4)
                c = CMD_UNUSED_LO + CMD_W'($urandom_range(0, 2));
            else if (roll < 14)
                c = CMD_DUMP;
            else if ($urandom_range(0, 99) < bias || occupancy == 0)
                c = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_REAR;
            else
                c = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_REAR;
            send_item(c, pick_value());
            if (c <= CMD_DUMP)
                sent++;
        end
        wait_drain();
        gap_max = 4;
    endtask

    // Empty the deque, pop once more to trip the underflow, then confirm
    // every code, ignored ones too, answers with a halted item.
    task automatic test_underflow_halt();
        int n;
        logic [3:0] code;
        while (occupancy != 0)
            send_item($urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_REAR, $urandom);
        send_item($urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_REAR, $urandom);
        for (code = 0; code <= CMD_UNUSED_HI; code++)
            send_item(code[CMD_W-1:0], pick_value());
        for (n = 0; n < 6; n++)
            send_item(CMD_W'($urandom_range(0, 7)), $urandom);
        wait_drain();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_ops();
        test_fill_overflow();
        test_backpressure();
        test_random();
        // Halt last: only a reset clears it.
        test_underflow_halt();
        if (errors == 0)
            $display("PASS bounded_deque");
        else
            $display("FAIL bounded_deque");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/bd_pkg.sv
hdl/bd_ctrl.sv
hdl/bd_datapath.sv
hdl/bounded_deque.sv
tb/testbench.sv
